>>> src/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

   // Ring geometry
   localparam int DEPTH = 16;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int WORD_W   = 32;
   localparam int OPCODE_W = 3;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_DUMP       = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd4;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_ELEM  = 2'd3
   } status_type;

   // Classified command kinds
   typedef enum logic [2:0] {
      CMD_PUSH_FRONT,
      CMD_PUSH_BACK,
      CMD_DUMP,
      CMD_POP_BACK,
      CMD_POP_FRONT,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic signed [WORD_W-1:0]  word;
   } cmd_type;

   // Back end sequencer states
   typedef enum logic {
      BK_IDLE,
      BK_DUMP
   } bk_state_type;

   // Back end status seen by the top level
   typedef struct packed {
      logic [CNT_W-1:0] occupancy;
      logic             dumping;
   } bk_status_type;

   // Add two ring indexes modulo DEPTH
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
      logic [PTR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (PTR_W+1)'(DEPTH)) begin
         sum = sum - (PTR_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

>>> src/dq_front.sv
`timescale 1ns / 1ps

module dq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dq_pkg::WORD_W-1:0]     req_tdata,   // [31:0] word_in
   input  logic [dq_pkg::OPCODE_W-1:0]   req_tuser,   // [2:0] opcode
   output logic                          cmd_valid,
   output dq_pkg::cmd_type               cmd,
   input  logic                          cmd_pop
);
   import dq_pkg::*;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    classified;
   logic       push;

   // Classify the incoming opcode
   always_comb begin
      classified.word = req_tdata;
      unique case (req_tuser)
         OP_PUSH_FRONT: classified.kind = CMD_PUSH_FRONT;
         OP_PUSH_BACK:  classified.kind = CMD_PUSH_BACK;
         OP_DUMP:       classified.kind = CMD_DUMP;
         OP_POP_BACK:   classified.kind = CMD_POP_BACK;
         OP_POP_FRONT:  classified.kind = CMD_POP_FRONT;
         default:       classified.kind = CMD_NOP;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = queue_ff[rd_ptr_ff];

   // Advance queue pointers and count
   always_comb begin
      wr_ptr_in = push    ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold classified items until the back end takes them
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

>>> src/dq_back.sv
`timescale 1ns / 1ps

module dq_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  dq_pkg::cmd_type               cmd,
   output logic                          cmd_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dq_pkg::WORD_W-1:0]     rsp_tdata,   // [31:0] word_out
   output logic [1:0]                    rsp_tuser,   // [1:0] status
   output logic                          rsp_tlast,
   output dq_pkg::bk_status_type         bk_status
);
   import dq_pkg::*;

   logic [WORD_W-1:0] slots_ff [DEPTH];

   bk_state_type      state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              load;
   logic              full;
   logic              empty;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [PTR_W-1:0]  rd_idx;
   logic [PTR_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              dump_last;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign full     = (occ_ff == CNT_W'(DEPTH));
   assign empty    = (occ_ff == '0);

   // Read the slot for the current dump position
   assign rd_idx    = (state_ff == BK_DUMP) ? idx_ff : '0;
   assign rd_addr   = ring_add(head_ff, rd_idx);
   assign rd_data   = slots_ff[rd_addr];
   assign dump_last = (CNT_W'(rd_idx) + CNT_W'(1)) == occ_ff;

   // Sequence commands and dumps
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      cmd_pop       = 1'b0;
      load          = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ring_add(head_ff, occ_ff[PTR_W-1:0]);
      rsp_status_in = ST_OK;
      rsp_word_in   = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               load    = 1'b1;
               unique case (cmd.kind)
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        head_in = (head_ff == '0) ? PTR_W'(DEPTH - 1)
                                                  : head_ff - PTR_W'(1);
                        wr_addr = head_in;
                        wr_en   = 1'b1;
                        occ_in  = occ_ff + CNT_W'(1);
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en  = 1'b1;
                        occ_in = occ_ff + CNT_W'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_status_in = ST_ELEM;
                        rsp_word_in   = rd_data;
                        rsp_last_in   = dump_last;
                        if (!dump_last) begin
                           state_in = BK_DUMP;
                           idx_in   = PTR_W'(1);
                        end
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        occ_in = occ_ff - CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        head_in = ring_add(head_ff, PTR_W'(1));
                        occ_in  = occ_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         BK_DUMP: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = ST_ELEM;
               rsp_word_in   = rd_data;
               rsp_last_in   = dump_last;
               if (dump_last) begin
                  state_in = BK_IDLE;
               end else begin
                  idx_in = idx_ff + PTR_W'(1);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the output register when a result is produced
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Write the slot store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= cmd.word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign bk_status.occupancy = occ_ff;
   assign bk_status.dumping   = (state_ff == BK_DUMP);

endmodule

>>> src/double_ended_queue_unit.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of 32-bit signed words (16 slots, a ring with
// head index and occupancy). Each request item carries an opcode in req_tuser
// (push front, push back, dump, pop back, pop front) and the push word in
// req_tdata. Every push, pop or unknown opcode gives one response item with a
// status in rsp_tuser (ok, empty, full) and tlast set; a dump streams every
// stored word front to back with status "element" and tlast on the final one,
// or one empty status when nothing is stored. Pops do not return the word.
// Rate: the back end executes one push or pop per cycle while the output
// register is free (rsp_tready stalls it), so those items sustain one per
// cycle; a dump occupies the back end for its whole run (one slot read per
// cycle, likewise held by rsp_tready) and takes no new command. A result
// passes through the two-entry command queue and then the output register.
// The slot store needs no clearing pass after reset.
module double_ended_queue_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dq_pkg::WORD_W-1:0]     req_tdata,   // [31:0] word_in
   input  logic [dq_pkg::OPCODE_W-1:0]   req_tuser,   // [2:0] opcode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dq_pkg::WORD_W-1:0]     rsp_tdata,   // [31:0] word_out
   output logic [1:0]                    rsp_tuser,   // [1:0] status
   output logic                          rsp_tlast
);
   import dq_pkg::*;

   logic          cmd_valid;
   cmd_type       cmd;
   logic          cmd_pop;
   bk_status_type bk_status;

   dq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   dq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .bk_status  (bk_status)
   );

   // Occupancy never passes the ring size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      bk_status.occupancy <= CNT_W'(DEPTH))
      else $error("occupancy beyond ring size");

   // A dump in progress always has words left to stream
   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      bk_status.dumping |-> bk_status.occupancy != '0)
      else $error("dump running on empty queue");

   // Status-only results carry a zero word and close their run
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_ELEM) |-> (rsp_tdata == '0 && rsp_tlast))
      else $error("status result with data or without last");

   // The back end takes no new command while a dump is streaming
   a_no_pop_in_dump: assert property (@(posedge clock) disable iff (reset)
      bk_status.dumping |-> !cmd_pop)
      else $error("command taken during dump");

endmodule
